FILE: hw/rtl/miller_rabin_prime_test_64_top_macros.svh
// ============================================================================
// Miller-Rabin 64 assertion macros
// Shared assertion forms for the checker.
// ============================================================================
`ifndef MILLER_RABIN_PRIME_TEST_64_TOP_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_64_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define MR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define MR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/mrpt_pkg.sv
// ============================================================================
// Miller-Rabin package
// Shared constants, witness table and controller/datapath command types.
// ============================================================================
package mrpt_pkg;

    localparam int W            = 64;
    localparam int TABLE_SIZE   = 12;
    localparam int WITNESS_DEF  = 12;
    localparam int WIDX_W       = 4;
    localparam int CNT_W        = 7;

    function automatic logic [5:0] witness(input logic [WIDX_W-1:0] i);
        case (i)
            4'd0:    witness = 6'd2;
            4'd1:    witness = 6'd3;
            4'd2:    witness = 6'd5;
            4'd3:    witness = 6'd7;
            4'd4:    witness = 6'd11;
            4'd5:    witness = 6'd13;
            4'd6:    witness = 6'd17;
            4'd7:    witness = 6'd19;
            4'd8:    witness = 6'd23;
            4'd9:    witness = 6'd29;
            4'd10:   witness = 6'd31;
            4'd11:   witness = 6'd37;
            default: witness = 6'd0;
        endcase
    endfunction

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1; // latch n, d = n-1, s = 0
    localparam logic [2:0] OP_SHIFT = 3'd2; // d >>= 1, s++
    localparam logic [2:0] OP_WINIT = 3'd3; // x=1, base=a, e=d
    localparam logic [2:0] OP_MULX  = 3'd4; // x = x*base mod n
    localparam logic [2:0] OP_SQB   = 3'd5; // base = base^2, e>>=1
    localparam logic [2:0] OP_SQX   = 3'd6; // x = x^2 mod n

    typedef struct packed {
        logic [2:0]        op;
        logic [WIDX_W-1:0] widx;
    } t_cmd;

    typedef struct packed {
        logic is_small;   // n <= 37
        logic small_prime;
        logic even;
        logic d_odd;
        logic e_zero;
        logic e_lsb;
        logic x_one;
        logic x_nm1;
        logic busy;       // modmul in progress
        logic [CNT_W-1:0] s;
    } t_sts;

endpackage

FILE: hw/rtl/mrpt_datapath.sv
// ============================================================================
// Miller-Rabin datapath
// Holds n, d, s, x, base, exponent and a bit-serial modular multiplier
// (one add-and-reduce step per cycle, one step per multiplier bit).
// ============================================================================
module mrpt_datapath
    import mrpt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_candidate,
    input  t_cmd         i_cmd,
    output t_sts         o_sts
);

    logic [W-1:0]     r_n, r_d, r_x, r_base, r_e;
    logic [CNT_W-1:0] r_s;
    logic [W-1:0]     r_ma, r_mb, r_acc;
    logic [6:0]       r_bit;
    logic             r_busy, r_dst_x, r_sqb;

    logic [W:0]   dbl, dbl_r, add, add_r;
    logic [W-1:0] step;

    always_comb begin
        dbl   = {r_acc, 1'b0};
        dbl_r = (dbl >= {1'b0, r_n}) ? dbl - {1'b0, r_n} : dbl;
        add   = dbl_r + {1'b0, r_ma};
        add_r = (add >= {1'b0, r_n}) ? add - {1'b0, r_n} : add;
        step  = r_mb[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_acc <= step;
            r_mb  <= {r_mb[W-2:0], 1'b0};
            r_bit <= r_bit - 7'd1;
            if (r_bit == 7'd1) begin
                r_busy <= 1'b0;
                if (r_dst_x) begin
                    r_x <= step;
                end else begin
                    r_base <= step;
                end
                if (r_sqb) begin
                    r_e <= {1'b0, r_e[W-1:1]};
                end
            end
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_n <= i_candidate;
                    r_d <= i_candidate - 64'd1;
                    r_s <= '0;
                end
                OP_SHIFT: begin
                    r_d <= {1'b0, r_d[W-1:1]};
                    r_s <= r_s + 7'd1;
                end
                OP_WINIT: begin
                    r_x    <= 64'd1;
                    r_base <= {58'd0, witness(i_cmd.widx)};
                    r_e    <= r_d;
                end
                OP_MULX, OP_SQB, OP_SQX: begin
                    r_busy  <= 1'b1;
                    r_bit   <= 7'd64;
                    r_acc   <= '0;
                    r_dst_x <= (i_cmd.op != OP_SQB);
                    r_sqb   <= (i_cmd.op == OP_SQB);
                    r_ma    <= (i_cmd.op == OP_SQB) ? r_base : r_x;
                    r_mb    <= (i_cmd.op == OP_MULX) ? r_base :
                               (i_cmd.op == OP_SQB) ? r_base : r_x;
                end
                default: begin
                end
            endcase
        end
    end

    logic sp;
    always_comb begin
        sp = 1'b0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (r_n == {58'd0, witness(WIDX_W'(i))}) begin
                sp = 1'b1;
            end
        end
        o_sts.is_small    = (r_n <= 64'd37);
        o_sts.small_prime = sp;
        o_sts.even        = ~r_n[0];
        o_sts.d_odd       = r_d[0];
        o_sts.e_zero      = (r_e == '0);
        o_sts.e_lsb       = r_e[0];
        o_sts.x_one       = (r_x == 64'd1);
        o_sts.x_nm1       = (r_x == r_n - 64'd1);
        o_sts.busy        = r_busy;
        o_sts.s           = r_s;
    end

endmodule

FILE: hw/rtl/mrpt_ctrl.sv
// ============================================================================
// Miller-Rabin controller
// Screens small and even candidates, then sequences the split of n-1,
// square-and-multiply and the squaring loop.
module mrpt_ctrl
    import mrpt_pkg::*;
#(
    parameter int WITNESS_COUNT = WITNESS_DEF
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output logic o_is_prime,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_SPLIT = 4'd2;
    localparam logic [3:0] S_WIT   = 4'd3;
    localparam logic [3:0] S_PSTEP = 4'd4;
    localparam logic [3:0] S_SQB   = 4'd5;
    localparam logic [3:0] S_TEST  = 4'd6;
    localparam logic [3:0] S_SQX   = 4'd7;
    localparam logic [3:0] S_SQCHK = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_WAITM = 4'd10;
    localparam logic [3:0] S_WAITB = 4'd11;

    localparam int CNT = (WITNESS_COUNT > TABLE_SIZE) ? TABLE_SIZE :
                         (WITNESS_COUNT < 1) ? 0 : WITNESS_COUNT;

    logic [3:0]        r_state, n_state;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic [CNT_W-1:0]  r_k, n_k;
    logic              r_res, n_res;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_DONE);
    assign o_is_prime = r_res;

    always_comb begin
        n_state   = r_state;
        n_widx    = r_widx;
        n_k       = r_k;
        n_res     = r_res;
        o_cmd.op  = OP_NONE;
        o_cmd.widx = r_widx;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.is_small) begin
                    n_res = i_sts.small_prime; n_state = S_DONE;
                end else if (i_sts.even) begin
                    n_res = 1'b0; n_state = S_DONE;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (!i_sts.d_odd) begin
                    o_cmd.op = OP_SHIFT;
                end else begin
                    n_widx = '0;
                    n_state = S_WIT;
                end
            end
            S_WIT: begin
                if (r_widx >= WIDX_W'(CNT)) begin
                    n_res = 1'b1; n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_WINIT;
                    n_state  = S_PSTEP;
                end
            end
            S_PSTEP: begin
                if (i_sts.e_zero) begin
                    n_state = S_TEST;
                end else if (i_sts.e_lsb) begin
                    o_cmd.op = OP_MULX;
                    n_state  = S_WAITM;
                end else begin
                    n_state = S_SQB;
                end
            end
            S_WAITM: begin
                if (!i_sts.busy) n_state = S_SQB;
            end
            S_SQB: begin
                o_cmd.op = OP_SQB;
                n_state  = S_WAITB;
            end
            S_WAITB: begin
                if (!i_sts.busy) n_state = S_PSTEP;
            end
            S_TEST: begin
                if (i_sts.x_one || i_sts.x_nm1) begin
                    n_widx = r_widx + 1'b1; n_state = S_WIT;
                end else begin
                    n_k = 7'd1; n_state = S_SQX;
                end
            end
            S_SQX: begin
                if (r_k >= i_sts.s) begin
                    n_res = 1'b0; n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_SQX;
                    n_state  = S_SQCHK;
                end
            end
            S_SQCHK: begin
                if (!i_sts.busy) begin
                    if (i_sts.x_nm1) begin
                        n_widx = r_widx + 1'b1; n_state = S_WIT;
                    end else begin
                        n_k = r_k + 7'd1; n_state = S_SQX;
                    end
                end
            end
            S_DONE: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_widx  <= '0;
            r_k     <= '0;
            r_res   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_k     <= n_k;
            r_res   <= n_res;
        end
    end

endmodule

FILE: hw/rtl/miller_rabin_prime_test_64_top.sv
// ============================================================================
// Miller-Rabin 64-bit prime test, top level
// Controller and datapath for a deterministic primality test.
// ============================================================================
// One candidate word at a time. Each modular product runs on a bit-serial
// add-and-reduce unit; an odd candidate above 37 runs its products for up to
// WITNESS_COUNT witnesses. Small or even inputs are decided in S_CHK and go
// straight to S_DONE. The result word is held until taken.
module miller_rabin_prime_test_64_top
    import mrpt_pkg::*;
#(
    parameter int WITNESS_COUNT = WITNESS_DEF
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_candidate,
    output logic         o_valid,
    input  logic         i_ready,
    output logic         o_is_prime
);

    t_cmd cmd;
    t_sts sts;

    mrpt_ctrl #(.WITNESS_COUNT(WITNESS_COUNT)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_is_prime, .i_sts(sts), .o_cmd(cmd)
    );

    mrpt_datapath u_dp (
        .i_clk, .i_rst_n, .i_candidate, .i_cmd(cmd), .o_sts(sts)
    );

endmodule

FILE: hw/rtl/mrpt_checker.sv
// ============================================================================
// Miller-Rabin port checker
// Port-level assertions bound to the top level.
// ============================================================================
`include "miller_rabin_prime_test_64_top_macros.svh"

module mrpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_is_prime
);

    `MR_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !o_ready)
    `MR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_is_prime))
    `MR_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_valid)

endmodule

bind miller_rabin_prime_test_64_top mrpt_checker u_chk (.*);

FILE: sim/miller_rabin_prime_test_64_top_tb.sv
// ============================================================================
// Miller-Rabin 64 prime test bench
// Drives candidate words through the valid/ready input and checks each
// is_prime word against a stored directed verdict or a behavioural primality
// predictor, under several idling patterns and one long receiver hold-off.
// ============================================================================
`timescale 1ns / 100ps

module miller_rabin_prime_test_64_top_tb;
    import mrpt_pkg::*;

    localparam int N_DIR  = 20;
    localparam int N_RAND = 370;
    localparam int N_ALL  = N_DIR + N_RAND;

    typedef struct {
        logic [W-1:0] cand;
        bit           known;
        bit           verdict;
    } t_row;

    localparam logic [5:0] PRIME_LIST [TABLE_SIZE] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_ready;
    logic [W-1:0] i_candidate;
    logic         o_valid;
    logic         i_ready;
    logic         o_is_prime;

    t_row  rows [N_ALL];
    bit    verdict_q [$];
    int    n_sent;
    int    n_err;
    int    hold_cnt;
    bit    sent_all;

    miller_rabin_prime_test_64_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_candidate (i_candidate),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_is_prime  (o_is_prime)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [W-1:0] mul_mod(logic [W-1:0] a, logic [W-1:0] b,
                                             logic [W-1:0] n);
        logic [2*W-1:0] p;
        p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
        return W'(p % {{W{1'b0}}, n});
    endfunction

    function automatic logic [W-1:0] pow_mod(logic [W-1:0] base, logic [W-1:0] e,
                                             logic [W-1:0] n);
        logic [W-1:0] acc;
        acc  = 1;
        base = base % n;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, base, n);
            e = e >> 1;
            if (e != 0) base = mul_mod(base, base, n);
        end
        return acc;
    endfunction

    function automatic bit is_prime_pred(logic [W-1:0] n);
        logic [W-1:0] d, nm1, x;
        int           s, cnt;
        bit           ok;
        if (n <= 37) begin
            foreach (PRIME_LIST[i])
                if (n == W'(PRIME_LIST[i])) return 1'b1;
            return 1'b0;
        end
        if (!n[0]) return 1'b0;
        nm1 = n - 1;
        d   = nm1;
        s   = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        cnt = (WITNESS_DEF > TABLE_SIZE) ? TABLE_SIZE : (WITNESS_DEF < 1) ? 0 : WITNESS_DEF;
        for (int i = 0; i < cnt; i++) begin
            x = pow_mod(W'(PRIME_LIST[i]), d, n);
            if (x == 1 || x == nm1) continue;
            ok = 1'b0;
            for (int k = 1; k < s; k++) begin
                x = mul_mod(x, x, n);
                if (x == nm1) begin
                    ok = 1'b1;
                    break;
                end
            end
            if (!ok) return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly fast candidates; a few full-width odd ones
    function automatic logic [W-1:0] rand_candidate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return W'($urandom_range(0, 40));
        if (r < 55) return {$urandom, $urandom} & ~64'd1;
        if (r < 85) return W'({$urandom_range(19, 8191), 1'b1});
        if (r < 95) return W'({$urandom_range(19, 1 << 19), 1'b1});
        return {$urandom, $urandom} | 64'd1;
    endfunction

    function automatic int phase_of(int idx);
        return (idx * 4) / N_ALL;
    endfunction

    initial begin
        t_row dir [N_DIR] = '{
            '{64'd0,                    1, 0},
            '{64'd1,                    1, 0},
            '{64'd2,                    1, 1},
            '{64'd4,                    1, 0},
            '{64'd31,                   1, 1},
            '{64'd36,                   1, 0},
            '{64'd37,                   1, 1},
            '{64'd38,                   1, 0},
            '{64'd39,                   0, 0},
            '{64'd41,                   0, 0},
            '{64'd49,                   0, 0},
            '{64'd561,                  0, 0},
            '{64'd1000000007,           0, 0},
            '{64'd3215031751,           0, 0},
            '{64'd3825123056546413051,  0, 0},
            '{64'h1FFF_FFFF_FFFF_FFFF,  0, 0},
            '{64'h8000_0000_0000_0000,  1, 0},
            '{64'hFFFF_FFFF_FFFF_FFFE,  1, 0},
            '{64'hFFFF_FFFF_FFFF_FFC5,  0, 0},
            '{64'hFFFF_FFFF_FFFF_FFFF,  0, 0}
        };
        foreach (dir[i]) rows[i] = dir[i];
        for (int i = N_DIR; i < N_ALL; i++) begin
            rows[i].cand  = rand_candidate();
            rows[i].known = 0;
        end
        for (int i = 0; i < N_ALL; i++)
            if (!rows[i].known) rows[i].verdict = is_prime_pred(rows[i].cand);
    end

    // sender
    initial begin
        int idx;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_candidate = '0;
        n_sent      = 0;
        sent_all    = 0;
        idx         = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_valid && o_ready) begin
                verdict_q.push_back(rows[idx].verdict);
                idx++;
                n_sent = idx;
            end
            if (!i_valid || o_ready) begin
                if (idx < N_ALL && !((phase_of(idx) == 1 && $urandom_range(0, 99) < 56) ||
                                     (phase_of(idx) == 3 && $urandom_range(0, 99) < 35))) begin
                    i_valid     <= 1'b1;
                    i_candidate <= rows[idx].cand;
                end else begin
                    i_valid <= 1'b0;
                end
                if (idx >= N_ALL) sent_all = 1;
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        hold_cnt = 0;
        wait (n_sent >= 3);
        @(posedge i_clk);
        hold_cnt = 400;
        while (hold_cnt > 0) begin
            @(posedge i_clk);
            hold_cnt--;
        end
    end

    // receiver and checker
    initial begin
        bit exp_v;
        int ph;
        i_ready = 1'b0;
        n_err   = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (verdict_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result word: %0b", o_is_prime);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_is_prime !== exp_v) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("is_prime mismatch: expected %0b, got %0b",
                                     exp_v, o_is_prime);
                    end
                end
            end
            ph = phase_of(n_sent);
            i_ready <= i_rst_n && hold_cnt == 0 &&
                       !((ph == 2 && $urandom_range(0, 99) < 56) ||
                         (ph == 3 && $urandom_range(0, 99) < 35));
        end
    end

    initial begin
        wait (sent_all);
        wait (verdict_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_err == 0 && verdict_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_datapath.sv
hw/rtl/mrpt_ctrl.sv
hw/rtl/miller_rabin_prime_test_64_top.sv
hw/rtl/mrpt_checker.sv
sim/miller_rabin_prime_test_64_top_tb.sv
